// ----- sv/pn3_pkg.sv -----
package pn3_pkg;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [7:0]         load_index;
        logic [7:0]         load_value;
    } t_in_beat;

    typedef struct packed {
        logic signed [17:0] noise_raw;
        logic [16:0]        noise_normalized;
    } t_out_beat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FADE,
        ST_HASH_ADDR,
        ST_HASH_WAIT,
        ST_HASH_DATA,
        ST_GRAD,
        ST_LERP,
        ST_CLAMP,
        ST_DIV,
        ST_OUT
    } t_state;

    // Fade micro-op steps (per axis)
    typedef enum logic [2:0] {
        FD_FF,
        FD_FFF,
        FD_F15,
        FD_P,
        FD_FADE
    } t_fade_step;

    localparam logic LOAD_MODE  = 1'b0;
    localparam logic NOISE_MODE = 1'b1;

    localparam int GridPeriod = 256;
    localparam int RawMax = 131071;
    localparam int RawMin = -131072;
    localparam int OneQ16 = 65536;

    function automatic logic signed [18:0] grad_q16(
        input logic [3:0]         h,
        input logic signed [17:0] x,
        input logic signed [17:0] y,
        input logic signed [17:0] z
    );
        logic signed [17:0] u;
        logic signed [17:0] v;
        logic signed [18:0] su;
        logic signed [18:0] sv;
        u = (h < 4'd8) ? x : y;
        v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
        su = h[0] ? -19'(u) : 19'(u);
        sv = h[1] ? -19'(v) : 19'(v);
        return su + sv;
    endfunction

endpackage

// ----- sv/perlin_noise_3d.sv -----
// Perlin 3D noise with a 256-entry permutation table and running min/max normalizer.
// Load beat (mode 0): one table write, no result beat.
// Noise beat (mode 1): after accept, the fade multiplies for each axis, then
// 8 corners x (3 dependent table reads + 1 gradient step), 7 lerps, a range
// update, a 17-step divide and an output load. Next beat is taken once the result leaves the output.
// Reset (synchronous, i_rst_n low): state to idle, min to 0, max to 1.0; table not cleared.
module perlin_noise_3d (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pn3_pkg::t_in_beat i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output pn3_pkg::t_out_beat o_out_data
);
    import pn3_pkg::*;

    localparam int IdxW = $clog2(GridPeriod);

    // Permutation table memory, registered read
    logic [7:0]      r_perm [GridPeriod];
    logic [IdxW-1:0] r_rd_addr;
    logic [7:0]      r_rd_data;

    t_state     r_state, n_state;
    logic [1:0] r_axis;        // axis for fade, hash level
    t_fade_step r_fstep;
    logic [2:0] r_corner;      // corner index: bit0=x, bit1=y, bit2=z
    logic [2:0] r_lstep;       // lerp step 0..6
    logic [4:0] r_dcnt;

    logic [15:0] r_frac [3];
    logic [7:0]  r_cell [3];
    logic [15:0] r_fade [3];   // fade fits in 17 bits only at f=1.0, which cannot occur
    logic [33:0] r_acc;        // fade scratch product
    logic [15:0] r_t3;
    logic [35:0] r_p;
    logic [7:0]  r_hv;         // running hash value
    logic signed [18:0] r_g [8];
    logic signed [17:0] r_raw;
    logic signed [17:0] r_min, r_max;
    logic [33:0] r_num;
    logic [18:0] r_den;
    logic [16:0] r_quo;
    logic [34:0] r_rem;
    t_out_beat   r_out;
    logic        r_out_valid;

    logic in_acc;
    assign o_in_stall  = (r_state != ST_IDLE) || r_out_valid;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Shared multiplier: 35 x 21 signed operands picked by the sequencer
    logic signed [34:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [55:0] mul_p;
    assign mul_p = mul_a * mul_b;

    // Absolute value with saturation
    function automatic logic [30:0] abs_sat(input logic signed [31:0] c);
        logic [31:0] m;
        m = c[31] ? (32'd0 - c) : c;
        return (m[31]) ? 31'h7FFFFFFF : m[30:0];
    endfunction

    // Lerp operand indexes: steps 0..3 pair x, 4..5 pair y, 6 z
    logic [2:0] la, lb;
    logic [15:0] lt;
    always_comb begin
        case (r_lstep)
            3'd0: begin la = 3'd0; lb = 3'd1; lt = r_fade[0]; end
            3'd1: begin la = 3'd2; lb = 3'd3; lt = r_fade[0]; end
            3'd2: begin la = 3'd4; lb = 3'd5; lt = r_fade[0]; end
            3'd3: begin la = 3'd6; lb = 3'd7; lt = r_fade[0]; end
            3'd4: begin la = 3'd0; lb = 3'd2; lt = r_fade[1]; end
            3'd5: begin la = 3'd4; lb = 3'd6; lt = r_fade[1]; end
            default: begin la = 3'd0; lb = 3'd4; lt = r_fade[2]; end
        endcase
    end

    logic [15:0] ff;
    assign ff = r_frac[r_axis];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == ST_FADE) begin
            case (r_fstep)
                FD_FF:   begin mul_a = 35'(ff); mul_b = 21'(ff); end
                FD_FFF:  begin mul_a = 35'(r_acc); mul_b = 21'(ff); end
                FD_F15:  begin mul_a = 35'(ff); mul_b = 21'sd15; end
                FD_P:    begin mul_a = 35'(r_p); mul_b = 21'sd6; end
                default: begin mul_a = 35'(r_t3); mul_b = 21'(r_p[35:16]); end
            endcase
        end else begin
            mul_a = 35'(lt);
            mul_b = 21'(r_g[lb] - r_g[la]);
        end
    end

    // Corner hash lookup index
    logic [7:0] hidx;
    always_comb begin
        case (r_axis)
            2'd0:    hidx = r_cell[0] + 8'(r_corner[0]);
            2'd1:    hidx = r_hv + r_cell[1] + 8'(r_corner[1]);
            default: hidx = r_hv + r_cell[2] + 8'(r_corner[2]);
        endcase
    end

    logic signed [17:0] gx, gy, gz;
    assign gx = 18'(r_frac[0]) - (r_corner[0] ? 18'sd65536 : 18'sd0);
    assign gy = 18'(r_frac[1]) - (r_corner[1] ? 18'sd65536 : 18'sd0);
    assign gz = 18'(r_frac[2]) - (r_corner[2] ? 18'sd65536 : 18'sd0);

    logic signed [39:0] lerp_sh;
    assign lerp_sh = 40'(mul_p) >>> 16;

    // Divide step: restoring, one quotient bit per cycle
    logic [34:0] rem_sh;
    logic [34:0] rem_sub;
    assign rem_sh  = {r_rem[33:0], r_num[33]};
    assign rem_sub = rem_sh - 35'(r_den);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (in_acc && i_in_data.mode == NOISE_MODE) n_state = ST_FADE;
            ST_FADE:      if (r_fstep == FD_FADE && r_axis == 2'd2) n_state = ST_HASH_ADDR;
            ST_HASH_ADDR: n_state = ST_HASH_WAIT;
            ST_HASH_WAIT: n_state = ST_HASH_DATA;
            ST_HASH_DATA: n_state = (r_axis == 2'd2) ? ST_GRAD : ST_HASH_ADDR;
            ST_GRAD:      n_state = (r_corner == 3'd7) ? ST_LERP : ST_HASH_ADDR;
            ST_LERP:      if (r_lstep == 3'd6) n_state = ST_CLAMP;
            ST_CLAMP:     n_state = ST_DIV;
            ST_DIV:       if (r_dcnt == 5'd16) n_state = ST_OUT;
            ST_OUT:       n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_min       <= '0;
            r_max       <= 18'sd65536;
            r_axis      <= '0;
            r_fstep     <= FD_FF;
            r_corner    <= '0;
            r_lstep     <= '0;
            r_dcnt      <= '0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    r_axis  <= '0;
                    r_fstep <= FD_FF;
                    r_corner <= '0;
                    r_lstep <= '0;
                    r_dcnt  <= '0;
                end
                ST_FADE: begin
                    if (r_fstep == FD_FADE) begin
                        r_fstep <= FD_FF;
                        r_axis  <= (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
                    end else begin
                        r_fstep <= t_fade_step'(r_fstep + 3'd1);
                    end
                end
                ST_HASH_DATA: r_axis <= (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
                ST_GRAD:      r_corner <= r_corner + 3'd1;
                ST_LERP:      r_lstep <= r_lstep + 3'd1;
                ST_DIV:       r_dcnt <= r_dcnt + 5'd1;
                ST_CLAMP: begin
                    if (r_raw < r_min) r_min <= r_raw;
                    if (r_raw > r_max) r_max <= r_raw;
                end
                ST_OUT: r_out_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    // Datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.mode == LOAD_MODE) begin
            r_perm[i_in_data.load_index[IdxW-1:0]] <= i_in_data.load_value;
        end
        r_rd_data <= r_perm[r_rd_addr];
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    logic [30:0] ax, ay, az;
                    ax = abs_sat(i_in_data.coord_x);
                    ay = abs_sat(i_in_data.coord_y);
                    az = abs_sat(i_in_data.coord_z);
                    r_frac[0] <= ax[15:0]; r_cell[0] <= ax[23:16];
                    r_frac[1] <= ay[15:0]; r_cell[1] <= ay[23:16];
                    r_frac[2] <= az[15:0]; r_cell[2] <= az[23:16];
                end
            end
            ST_FADE: begin
                case (r_fstep)
                    FD_FF:  r_acc <= 34'(mul_p);
                    // t3 = f^3 >> 32; keep f^2 for p in r_p
                    FD_FFF: begin
                        r_t3 <= 16'(mul_p >>> 32);
                        r_p  <= 36'(r_acc);
                    end
                    FD_F15: r_acc <= 34'(mul_p);
                    FD_P: begin
                        // p = 10<<32 + 6 f^2 - 15 f <<16
                        r_p <= (36'd10 << 32) + 36'(mul_p) - (36'(r_acc) << 16);
                    end
                    default: r_fade[r_axis] <= 16'(mul_p >>> 16);
                endcase
            end
            ST_HASH_ADDR: r_rd_addr <= IdxW'(hidx);
            ST_HASH_DATA: r_hv <= r_rd_data;
            ST_GRAD: r_g[r_corner] <= grad_q16(r_hv[3:0], gx, gy, gz);
            ST_LERP: begin
                if (r_lstep == 3'd6) begin
                    logic signed [39:0] rv;
                    rv = 40'(r_g[la]) + lerp_sh;
                    if (rv > 40'sd131071) r_raw <= 18'sd131071;
                    else if (rv < -40'sd131072) r_raw <= -18'sd131072;
                    else r_raw <= 18'(rv);
                end else begin
                    r_g[la] <= 19'(40'(r_g[la]) + lerp_sh);
                end
            end
            ST_CLAMP: begin
                logic signed [17:0] mn, mx;
                logic [17:0]        diff;
                mn = (r_raw < r_min) ? r_raw : r_min;
                mx = (r_raw > r_max) ? r_raw : r_max;
                diff = 18'(r_raw - mn);
                // Quotient fits 17 bits: preload the top 17 dividend bits
                r_rem <= 35'(diff[17:1]);
                r_num <= {diff[0], 33'd0};
                r_den <= 19'(20'(mx) - 20'(mn));
                r_quo <= '0;
            end
            ST_DIV: begin
                r_num <= {r_num[32:0], 1'b0};
                if (!rem_sub[34]) begin
                    r_rem <= rem_sub;
                    r_quo <= {r_quo[15:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_quo <= {r_quo[15:0], 1'b0};
                end
            end
            ST_OUT: begin
                r_out.noise_raw        <= r_raw;
                r_out.noise_normalized <= r_quo;
            end
            default: ;
        endcase
    end

    // Running range always spans at least 1.0; the check also accepts a range that straddles zero
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_max - r_min) >= 18'sd65536 || (r_max > 18'sd0 && r_min < 18'sd0))
        else $error("min/max span shrank");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_in_stall)
        else $error("accepted beat while busy");
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |=> o_out_valid)
        else $error("result lost");
    a_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.noise_normalized <= 17'd65536)
        else $error("normalized value over 1.0");

endmodule
